// File: src/u8t_pkg.sv
`timescale 1ns / 1ps

package u8t_pkg;

    // Frame geometry and register defaults
    localparam int unsigned DATA_BITS_DEF  = 8;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned HALF_W         = 7;
    localparam int unsigned TIMER_W        = 8;
    localparam int unsigned COUNT_W        = 4;
    localparam logic [HALF_W-1:0] HALF_BIT_RESET = 7'd4;

    // Configuration register map
    localparam int unsigned ADDR_W         = 3;
    localparam int unsigned APB_DATA_W     = 32;
    localparam logic [ADDR_W-1:0] ADDR_HALF_BIT = 3'd0;

    // Stream payload layout
    localparam int unsigned IN_DATA_W      = 16;
    localparam int unsigned OUT_DATA_W     = 16;

    // Output tdata bit positions
    localparam int unsigned OUT_TX_LEVEL   = 0;
    localparam int unsigned OUT_TX_BUSY    = 1;
    localparam int unsigned OUT_RX_VALID   = 2;
    localparam int unsigned OUT_RX_BYTE_LO = 3;

    typedef enum logic [3:0] {
        RX_IDLE  = 4'b0001,
        RX_START = 4'b0010,
        RX_DATA  = 4'b0100,
        RX_TAIL  = 4'b1000
    } t_rx_phase;

endpackage

// File: src/uart_8n1_transceiver.sv
// A tick transferred in on s_axis is registered and appears on m_axis in the next cycle.
// Throughput: one tick per cycle; the output register is refilled in the same
// cycle it is drained, so the stream only stalls while m_axis_tready is low.
// Reset: synchronous, active low; both line state machines return to idle,
// the transmit line to high and r_half to 4.
`timescale 1ns / 1ps

module uart_8n1_transceiver #(
    parameter int unsigned DATA_BITS = u8t_pkg::DATA_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [u8t_pkg::ADDR_W-1:0]        paddr,
    input  logic [u8t_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [u8t_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // Tick input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // rx_level [0], send_valid [1], send_byte [9:2], zero [15:10]
    input  logic [u8t_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Tick result
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tx_level [0], tx_busy [1], rx_valid [2], rx_byte [10:3], zero [15:11]
    output logic [u8t_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam logic [u8t_pkg::COUNT_W-1:0] DB      = u8t_pkg::COUNT_W'(DATA_BITS);
    localparam logic [u8t_pkg::COUNT_W-1:0] STOP_CT = u8t_pkg::COUNT_W'(DATA_BITS + 2);

    logic [u8t_pkg::HALF_W-1:0]   r_half;
    u8t_pkg::t_rx_phase           r_rx_phase,  n_rx_phase;
    logic [u8t_pkg::TIMER_W-1:0]  r_rx_timer,  n_rx_timer;
    logic [u8t_pkg::COUNT_W-1:0]  r_rx_count,  n_rx_count;
    logic [u8t_pkg::BYTE_W-1:0]   r_rx_shift,  n_rx_shift;
    logic [u8t_pkg::TIMER_W-1:0]  r_tx_timer,  n_tx_timer;
    logic [u8t_pkg::COUNT_W-1:0]  r_tx_count,  n_tx_count;
    logic [u8t_pkg::BYTE_W-1:0]   r_tx_shift,  n_tx_shift;
    logic                         r_tx_line,   n_tx_line;
    logic                         r_out_valid;
    logic [u8t_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                         cfg_wr;
    logic                         in_xfer;
    logic [u8t_pkg::HALF_W-1:0]   half;
    logic [u8t_pkg::TIMER_W-1:0]  half_t, full_t;
    logic [u8t_pkg::TIMER_W-1:0]  rx_dec, tx_dec;
    logic                         rx_exp, tx_exp;
    logic                         in_level, in_req;
    logic [u8t_pkg::BYTE_W-1:0]   in_byte;
    logic                         rx_valid;
    logic [u8t_pkg::BYTE_W-1:0]   rx_out;
    logic [u8t_pkg::COUNT_W-1:0]  tx_inc, tx_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (paddr == u8t_pkg::ADDR_HALF_BIT)
                   ? u8t_pkg::APB_DATA_W'(r_half) : '0;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign in_level = s_axis_tdata[0];
    assign in_req   = s_axis_tdata[1];
    assign in_byte  = s_axis_tdata[9:2];

    // A zero setting behaves as one tick per half bit.
    assign half   = (r_half == '0) ? u8t_pkg::HALF_W'(1) : r_half;
    assign half_t = {1'b0, half};
    assign full_t = {half, 1'b0};

    assign rx_dec = (r_rx_timer != '0) ? r_rx_timer - 8'd1 : r_rx_timer;
    assign rx_exp = (rx_dec == '0);
    assign tx_dec = (r_tx_timer != '0) ? r_tx_timer - 8'd1 : r_tx_timer;
    assign tx_exp = (tx_dec == '0);
    assign tx_inc = r_tx_count + 4'd1;
    assign tx_idx = tx_inc - 4'd2;

    // Receiver
    always_comb begin
        n_rx_phase = r_rx_phase;
        n_rx_timer = r_rx_timer;
        n_rx_count = r_rx_count;
        n_rx_shift = r_rx_shift;
        rx_valid   = 1'b0;
        rx_out     = '0;
        unique case (r_rx_phase)
            u8t_pkg::RX_IDLE: begin
                if (!in_level) begin
                    n_rx_phase = u8t_pkg::RX_START;
                    n_rx_timer = full_t;
                    n_rx_count = '0;
                    n_rx_shift = '0;
                end
            end
            u8t_pkg::RX_START: begin
                n_rx_timer = rx_dec;
                if (rx_exp) begin
                    n_rx_phase = u8t_pkg::RX_DATA;
                    n_rx_timer = half_t;
                end
            end
            u8t_pkg::RX_DATA: begin
                n_rx_timer = rx_dec;
                if (rx_exp) begin
                    // Bits beyond the eighth are counted but not stored.
                    if (r_rx_count < 4'd8 && in_level) begin
                        n_rx_shift[r_rx_count[2:0]] = 1'b1;
                    end
                    n_rx_count = r_rx_count + 4'd1;
                    n_rx_timer = full_t;
                    if (n_rx_count >= DB) begin
                        n_rx_phase = u8t_pkg::RX_TAIL;
                    end
                end
            end
            u8t_pkg::RX_TAIL: begin
                n_rx_timer = rx_dec;
                if (rx_exp) begin
                    rx_valid   = 1'b1;
                    rx_out     = r_rx_shift;
                    n_rx_phase = u8t_pkg::RX_IDLE;
                end
            end
            default: begin
                n_rx_phase = u8t_pkg::RX_IDLE;
            end
        endcase
    end

    // Transmitter; a count of zero means idle.
    always_comb begin
        n_tx_timer = r_tx_timer;
        n_tx_count = r_tx_count;
        n_tx_shift = r_tx_shift;
        n_tx_line  = r_tx_line;
        if (r_tx_count != '0) begin
            n_tx_timer = tx_dec;
            if (tx_exp) begin
                if (tx_inc > STOP_CT || tx_inc == '0) begin
                    n_tx_count = '0;
                    n_tx_line  = 1'b1;
                end else begin
                    n_tx_count = tx_inc;
                    n_tx_timer = full_t;
                    if (tx_inc == STOP_CT) begin
                        n_tx_line = 1'b1;
                    end else begin
                        n_tx_line = (tx_idx < 4'd8) ? r_tx_shift[tx_idx[2:0]] : 1'b0;
                    end
                end
            end
        end
        // The transmitter may take a new request on the tick its stop bit ends.
        if (n_tx_count == '0) begin
            if (in_req) begin
                n_tx_count = 4'd1;
                n_tx_shift = in_byte;
                n_tx_timer = full_t;
                n_tx_line  = 1'b0;
            end else begin
                n_tx_line  = 1'b1;
            end
        end
    end

    always_comb begin
        n_out_data = '0;
        n_out_data[u8t_pkg::OUT_TX_LEVEL] = n_tx_line;
        n_out_data[u8t_pkg::OUT_TX_BUSY]  = (n_tx_count != '0);
        n_out_data[u8t_pkg::OUT_RX_VALID] = rx_valid;
        n_out_data[u8t_pkg::OUT_RX_BYTE_LO +: u8t_pkg::BYTE_W] = rx_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= u8t_pkg::HALF_BIT_RESET;
            r_rx_phase  <= u8t_pkg::RX_IDLE;
            r_rx_timer  <= '0;
            r_rx_count  <= '0;
            r_rx_shift  <= '0;
            r_tx_timer  <= '0;
            r_tx_count  <= '0;
            r_tx_shift  <= '0;
            r_tx_line   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr && paddr == u8t_pkg::ADDR_HALF_BIT) begin
                r_half <= pwdata[u8t_pkg::HALF_W-1:0];
            end
            if (in_xfer) begin
                r_rx_phase <= n_rx_phase;
                r_rx_timer <= n_rx_timer;
                r_rx_count <= n_rx_count;
                r_rx_shift <= n_rx_shift;
                r_tx_timer <= n_tx_timer;
                r_tx_count <= n_tx_count;
                r_tx_shift <= n_tx_shift;
                r_tx_line  <= n_tx_line;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// File: src/u8t_checker.sv
`timescale 1ns / 1ps

module u8t_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [u8t_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled result must be held until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // An empty output register always leaves room for the next tick.
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // An idle transmitter drives the line high.
    a_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[u8t_pkg::OUT_TX_BUSY]
        |-> m_axis_tdata[u8t_pkg::OUT_TX_LEVEL])
        else $error("idle transmitter drives line low");

    // The received byte field is zero unless a byte completes.
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[u8t_pkg::OUT_RX_VALID]
        |-> m_axis_tdata[u8t_pkg::OUT_RX_BYTE_LO +: u8t_pkg::BYTE_W] == '0)
        else $error("received byte shown without rx_valid");

    // A tick transferred in shows up as a result in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("result missing after input transfer");

endmodule

bind uart_8n1_transceiver u8t_checker u_u8t_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
